### rtl/agdfs_pkg.sv
// Package for the adjacency-list depth-first walker.
// Holds the input/result transaction structs and the operation codes.
// No dependencies.
`timescale 1ns / 1ps
package agdfs_pkg;

  localparam int unsigned VertW = 5;
  localparam int unsigned WgtW  = 16;
  localparam int unsigned CntW  = 9;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpRemove = 2'd1,
    OpWalk   = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [VertW-1:0] start_vertex;
    logic [VertW-1:0] end_vertex;
    logic signed [WgtW-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [VertW-1:0] visited_vertex;
    logic             status;
    logic             last;
    logic [CntW-1:0]  edge_count;
  } out_item_t;

endpackage

### rtl/adjacency_graph_dfs_walker.sv
// Top level of the adjacency-list depth-first walker.
// Depends on agdfs_pkg.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid_i/stall_o | agdfs_pkg::in_item_t
//   out     | output    | out_valid_o/stall_i| agdfs_pkg::out_item_t
//   cfg     | input     | cfg_we_i           | cfg_wdata_i (vertex_count)
//
// One transaction is processed at a time; the neighbor and stack memories have
// a registered read port. An add writes the entry in StAdd and then hands off
// its result; a rejected item goes straight to the result hand-off. Remove
// searches the list, then shifts the tail down, one entry per read and write.
// A walk reads neighbor entries, pops finished vertices through the stack
// memory and hands off one result per visited vertex. Reset clears degrees,
// totals and visited bits at once; the memories need no clearing. A stalled
// result holds the engine in its wait state.
`timescale 1ns / 1ps
module adjacency_graph_dfs_walker #(
  parameter int unsigned MAX_VERTS  = 32,
  parameter int unsigned MAX_DEGREE = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [5:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  agdfs_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output agdfs_pkg::out_item_t out_data_o
);
  import agdfs_pkg::*;

  localparam int unsigned VIdxW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int unsigned PosW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned DegW  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned SpW   = $clog2(MAX_VERTS + 1);
  localparam int unsigned ResW  = 6;
  localparam int unsigned MaxRes = 32;
  localparam int unsigned Depth = MAX_VERTS * MAX_DEGREE;
  localparam int unsigned AddrW = VIdxW + PosW;
  localparam int unsigned EntW  = VertW + WgtW;

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StAdd   = 10'b0000000010,
    StRmRd  = 10'b0000000100,
    StRmChk = 10'b0000001000,
    StShRd  = 10'b0000010000,
    StShWr  = 10'b0000100000,
    StWkTop = 10'b0001000000,
    StWkChk = 10'b0010000000,
    StWkPop = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Neighbor memory: destination and weight per slot.
  logic [EntW-1:0] nbr_mem [Depth];
  logic            mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      nbr_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= nbr_mem[mem_raddr];
  end

  logic [SpW-1:0]    sp_q;

  // Walk stack memory: vertex and next position.
  logic [VIdxW+DegW-1:0] stk_mem [MAX_VERTS];
  logic                  stk_we;
  logic [VIdxW-1:0]      stk_waddr, stk_raddr;
  logic [VIdxW+DegW-1:0] stk_wdata, stk_rdata_q;

  // entry just below the cached top
  assign stk_raddr = VIdxW'(sp_q - SpW'(2));

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  logic [DegW-1:0]   deg_q [MAX_VERTS];
  logic [MAX_VERTS-1:0] vis_q;
  logic [CntW-1:0]   total_q;
  logic [6:0]        nverts_q;
  logic [1:0]        op_q;
  logic [VIdxW-1:0]  src_q;
  logic [VertW-1:0]  dst_q;
  logic [WgtW-1:0]   wgt_q;
  logic [DegW-1:0]   idx_q;      // search / shift position
  logic [VIdxW-1:0]  top_v_q;    // cached top of stack
  logic [DegW-1:0]   top_p_q;
  logic [ResW:0]     cnt_q;
  logic [VertW-1:0]  pend_q;     // newest preorder vertex, not yet sent
  out_item_t         res_q;

  logic [6:0] n_act;
  assign n_act = (nverts_q > 7'(MAX_VERTS)) ? 7'(MAX_VERTS) : nverts_q;

  logic s_ok, e_ok;
  assign s_ok = {2'b0, in_data_i.start_vertex} < n_act;
  assign e_ok = {2'b0, in_data_i.end_vertex} < n_act;

  logic [VIdxW-1:0] in_s;
  assign in_s = VIdxW'(in_data_i.start_vertex);

  logic accept;
  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = res_q;

  logic [VertW-1:0] rd_dst;
  assign rd_dst = mem_rdata_q[EntW-1 -: VertW];

  // walk: destination acceptance
  logic w_in_range, w_take;
  assign w_in_range = ({2'b0, rd_dst} < 7'(MAX_VERTS));
  assign w_take = w_in_range && !vis_q[VIdxW'(rd_dst)] &&
                  (sp_q < SpW'(MAX_VERTS)) && (cnt_q < (ResW+1)'(MaxRes));

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = {src_q, PosW'(idx_q)};
    mem_wdata = mem_rdata_q;
    mem_raddr = {src_q, PosW'(idx_q)};
    stk_we    = 1'b0;
    stk_waddr = VIdxW'(sp_q);
    stk_wdata = {top_v_q, top_p_q};
    unique case (state_q)
      StIdle:  ;
      StAdd: begin
        mem_we    = 1'b1;
        mem_waddr = {src_q, PosW'(deg_q[src_q])};
        mem_wdata = {dst_q, wgt_q};
      end
      StRmRd:  ;
      StRmChk: ;
      StShRd:  mem_raddr = {src_q, PosW'(idx_q + DegW'(1))};
      StShWr:  mem_we = 1'b1;
      StWkTop: mem_raddr = {top_v_q, PosW'(top_p_q)};
      StWkChk: begin
        if (w_take) begin
          // save parent with advanced position before pushing child
          stk_we    = 1'b1;
          stk_waddr = VIdxW'(sp_q - SpW'(1));
          stk_wdata = {top_v_q, top_p_q + DegW'(1)};
        end
      end
      StWkPop: ;
      StOut:   ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      nverts_q    <= '0;
      total_q     <= '0;
      vis_q       <= '0;
      sp_q        <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < MAX_VERTS; i++) deg_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        nverts_q <= {1'b0, cfg_wdata_i};
        total_q  <= '0;
        for (int i = 0; i < MAX_VERTS; i++) deg_q[i] <= '0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            op_q  <= in_data_i.op;
            src_q <= in_s;
            dst_q <= in_data_i.end_vertex;
            wgt_q <= in_data_i.weight;
            idx_q <= '0;
            res_q <= '{visited_vertex: '0, status: 1'b1, last: 1'b1, edge_count: total_q};
            priority case (in_data_i.op)
              OpAdd: begin
                if (s_ok && e_ok && deg_q[in_s] < DegW'(MAX_DEGREE)) state_q <= StAdd;
                else state_q <= StOut;
              end
              OpRemove: begin
                if (s_ok && deg_q[in_s] != '0) state_q <= StRmRd;
                else state_q <= StOut;
              end
              OpWalk: begin
                if (s_ok) begin
                  vis_q       <= '0;
                  vis_q[in_s] <= 1'b1;
                  top_v_q     <= in_s;
                  top_p_q     <= '0;
                  sp_q        <= SpW'(1);
                  cnt_q       <= (ResW+1)'(1);
                  pend_q      <= in_data_i.start_vertex;
                  state_q     <= StWkTop;
                end else begin
                  state_q <= StOut;
                end
              end
              default: state_q <= StOut;
            endcase
          end
        end
        StAdd: begin
          deg_q[src_q] <= deg_q[src_q] + DegW'(1);
          total_q      <= total_q + CntW'(1);
          res_q        <= '{visited_vertex: '0, status: 1'b0, last: 1'b1,
                            edge_count: total_q + CntW'(1)};
          state_q      <= StOut;
        end
        StRmRd: state_q <= StRmChk;
        StRmChk: begin
          if (rd_dst == dst_q) begin
            state_q <= StShRd;
          end else if (idx_q + DegW'(1) >= deg_q[src_q]) begin
            state_q <= StOut;
          end else begin
            idx_q   <= idx_q + DegW'(1);
            state_q <= StRmRd;
          end
        end
        StShRd: begin
          if (idx_q + DegW'(1) >= deg_q[src_q]) begin
            deg_q[src_q] <= deg_q[src_q] - DegW'(1);
            total_q <= (total_q != '0) ? total_q - CntW'(1) : total_q;
            res_q <= '{visited_vertex: '0, status: 1'b0, last: 1'b1,
                       edge_count: (total_q != '0) ? total_q - CntW'(1) : total_q};
            state_q <= StOut;
          end else begin
            state_q <= StShWr;
          end
        end
        StShWr: begin
          idx_q   <= idx_q + DegW'(1);
          state_q <= StShRd;
        end
        StWkTop: begin
          if (top_p_q >= deg_q[top_v_q]) begin
            if (sp_q == SpW'(1)) begin
              // final pop: the held vertex closes the walk
              res_q <= '{visited_vertex: pend_q, status: 1'b0, last: 1'b1,
                         edge_count: total_q};
              sp_q    <= '0;
              state_q <= StOut;
            end else begin
              // pop; the parent arrives from the stack memory next cycle
              sp_q    <= sp_q - SpW'(1);
              state_q <= StWkPop;
            end
          end else begin
            state_q <= StWkChk;
          end
        end
        StWkChk: begin
          if (w_take) begin
            // a new push proves the held vertex is not the last one
            vis_q[VIdxW'(rd_dst)] <= 1'b1;
            top_v_q <= VIdxW'(rd_dst);
            top_p_q <= '0;
            sp_q    <= sp_q + SpW'(1);
            cnt_q   <= cnt_q + (ResW+1)'(1);
            pend_q  <= rd_dst;
            res_q <= '{visited_vertex: pend_q, status: 1'b0, last: 1'b0,
                       edge_count: total_q};
            state_q <= StOut;
          end else begin
            top_p_q <= top_p_q + DegW'(1);
            state_q <= StWkTop;
          end
        end
        StWkPop: begin
          {top_v_q, top_p_q} <= stk_rdata_q;
          state_q <= StWkTop;
        end
        StOut: begin
          if (!out_stall_i) begin
            // a walk result that is not the last resumes the search
            if (op_q == OpWalk && !res_q.last) begin
              state_q <= StWkTop;
            end else begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

### rtl/agdfs_checker.sv
// Port-level checker for the depth-first walker.
// Depends on agdfs_pkg; bound to adjacency_graph_dfs_walker.
`timescale 1ns / 1ps
module agdfs_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input agdfs_pkg::out_item_t out_data_o
);
  import agdfs_pkg::*;

  // one transaction in flight: a result never shows while input is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.last &&
    out_data_o.visited_vertex == '0) else $error("rejected result malformed");
endmodule

bind adjacency_graph_dfs_walker agdfs_checker u_agdfs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);
